### sv/ard_pkg.sv
// Shared types and codes for the array deque block.
`default_nettype none

package ard_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Request mode codes as they arrive on the input stream
    localparam logic [2:0] MODE_INS_FRONT  = 3'd0;
    localparam logic [2:0] MODE_INS_END    = 3'd1;
    localparam logic [2:0] MODE_DEL_FRONT  = 3'd2;
    localparam logic [2:0] MODE_DEL_END    = 3'd3;
    localparam logic [2:0] MODE_LIST_FRONT = 3'd4;
    localparam logic [2:0] MODE_LIST_END   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        OP_INS_FRONT,
        OP_INS_END,
        OP_DEL_FRONT,
        OP_DEL_END,
        OP_LIST_FRONT,
        OP_LIST_END,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic              is_empty;
        logic              is_full;
        logic              last;
    } res_t;

    typedef enum logic {
        BK_IDLE,
        BK_LIST
    } back_state_t;

endpackage

`default_nettype wire

### sv/ard_front.sv
// Front end: accepts request words, decodes the mode and queues commands.
`default_nettype none

module ard_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [2:0]                       s_mode,
    input  wire logic [ard_pkg::DATA_W-1:0]       s_data,
    output logic                                  cmd_valid,
    input  wire logic                             cmd_ready,
    output ard_pkg::cmd_t                         cmd
);

    ard_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;
    ard_pkg::op_t  op_dec;

    always_comb begin
        case (s_mode)
            ard_pkg::MODE_INS_FRONT:  op_dec = ard_pkg::OP_INS_FRONT;
            ard_pkg::MODE_INS_END:    op_dec = ard_pkg::OP_INS_END;
            ard_pkg::MODE_DEL_FRONT:  op_dec = ard_pkg::OP_DEL_FRONT;
            ard_pkg::MODE_DEL_END:    op_dec = ard_pkg::OP_DEL_END;
            ard_pkg::MODE_LIST_FRONT: op_dec = ard_pkg::OP_LIST_FRONT;
            ard_pkg::MODE_LIST_END:   op_dec = ard_pkg::OP_LIST_END;
            default:                  op_dec = ard_pkg::OP_NOP;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, data: s_data};
        end
    end

endmodule

`default_nettype wire

### sv/ard_back.sv
// Back end: owns the store and indices, executes commands, drives results.
`default_nettype none

module ard_back #(
    parameter int DEPTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire ard_pkg::cmd_t cmd,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ard_pkg::res_t      m_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH - 1);

    logic [ard_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ard_pkg::DATA_W-1:0] rd_data_reg;

    ard_pkg::back_state_t state_reg, state_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic                 occ_reg, occ_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [ard_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic                 dir_reg, dir_next;

    logic                 pend_valid_reg;
    ard_pkg::res_t        pend_reg;
    logic                 pend_mem_reg;
    logic                 out_valid_reg;
    ard_pkg::res_t        out_reg;

    logic                 o_free, p_take;
    logic                 new_pend, new_mem;
    ard_pkg::res_t        new_res;
    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_wa, mem_ra;
    logic [IW:0]          span;

    assign o_free = !out_valid_reg || m_ready;
    assign p_take = !pend_valid_reg || o_free;
    assign span   = {1'b0, tail_reg} - {1'b0, head_reg} + {{IW{1'b0}}, 1'b1};

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        dir_next   = dir_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wa     = '0;
        mem_ra     = '0;
        new_pend   = 1'b0;
        new_mem    = 1'b0;
        new_res    = '{status: ard_pkg::ST_DONE, value: '0, is_empty: 1'b0,
                       is_full: 1'b0, last: 1'b1};
        case (state_reg)
            ard_pkg::BK_IDLE: begin
                if (cmd_valid && p_take) begin
                    cmd_ready = 1'b1;
                    new_pend  = 1'b1;
                    case (cmd.op)
                        ard_pkg::OP_INS_FRONT: begin
                            if (!occ_reg) begin
                                head_next = '0;
                                tail_next = '0;
                                occ_next  = 1'b1;
                                mem_we    = 1'b1;
                            end else if (head_reg == '0) begin
                                new_res.status = ard_pkg::ST_NOROOM;
                            end else begin
                                head_next = head_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_wa    = head_reg - 1'b1;
                            end
                        end
                        ard_pkg::OP_INS_END: begin
                            if (!occ_reg) begin
                                head_next = '0;
                                tail_next = '0;
                                occ_next  = 1'b1;
                                mem_we    = 1'b1;
                            end else if (tail_reg == TOP_IDX) begin
                                new_res.status = ard_pkg::ST_NOROOM;
                            end else begin
                                tail_next = tail_reg + 1'b1;
                                mem_we    = 1'b1;
                                mem_wa    = tail_reg + 1'b1;
                            end
                        end
                        ard_pkg::OP_DEL_FRONT, ard_pkg::OP_DEL_END: begin
                            if (!occ_reg) begin
                                new_res.status = ard_pkg::ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                new_mem = 1'b1;
                                mem_ra  = (cmd.op == ard_pkg::OP_DEL_FRONT) ?
                                          head_reg : tail_reg;
                                if (head_reg == tail_reg) begin
                                    head_next = '0;
                                    tail_next = '0;
                                    occ_next  = 1'b0;
                                end else if (cmd.op == ard_pkg::OP_DEL_FRONT) begin
                                    head_next = head_reg + 1'b1;
                                end else begin
                                    tail_next = tail_reg - 1'b1;
                                end
                            end
                        end
                        ard_pkg::OP_LIST_FRONT, ard_pkg::OP_LIST_END: begin
                            if (!occ_reg) begin
                                new_res.status = ard_pkg::ST_EMPTY;
                            end else begin
                                // start the walk; results come from the list state
                                new_pend   = 1'b0;
                                state_next = ard_pkg::BK_LIST;
                                dir_next   = (cmd.op == ard_pkg::OP_LIST_END);
                                idx_next   = (cmd.op == ard_pkg::OP_LIST_END) ?
                                             tail_reg : head_reg;
                                if (int'(span) > ard_pkg::MAX_RESULTS) begin
                                    rem_next = ard_pkg::CNT_W'(ard_pkg::MAX_RESULTS);
                                end else begin
                                    rem_next = ard_pkg::CNT_W'(span);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ard_pkg::BK_LIST: begin
                if (p_take) begin
                    mem_re         = 1'b1;
                    mem_ra         = idx_reg;
                    new_pend       = 1'b1;
                    new_mem        = 1'b1;
                    new_res.last   = (rem_reg == ard_pkg::CNT_W'(1));
                    idx_next       = dir_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == ard_pkg::CNT_W'(1)) begin
                        state_next = ard_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = ard_pkg::BK_IDLE;
            end
        endcase
        new_res.is_empty = !occ_next;
        new_res.is_full  = occ_next && (tail_next == TOP_IDX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ard_pkg::BK_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            dir_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            dir_reg   <= dir_next;
            if (p_take) begin
                pend_valid_reg <= new_pend;
            end
            if (o_free) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    // Payload: pending stage waits for read data, output stage holds under stall
    always_ff @(posedge aclk) begin
        if (p_take) begin
            pend_reg     <= new_res;
            pend_mem_reg <= new_mem;
        end
        if (o_free && pend_valid_reg) begin
            out_reg <= '{status:   pend_reg.status,
                         value:    pend_mem_reg ? rd_data_reg
                                                : {ard_pkg::DATA_W{1'b0}},
                         is_empty: pend_reg.is_empty,
                         is_full:  pend_reg.is_full,
                         last:     pend_reg.last};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= cmd.data;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

`default_nettype wire

### sv/array_deque_unit.sv
// Array deque: a double-ended queue held in a linear array of DEPTH words.
//
// Input stream (s_*): one request word per item, mode selects insert front,
// insert end, delete front, delete end, list from front or list from end.
// Output stream (m_*): one result word per insert or delete; a listing gives
// one word per stored element (at most 64), m_tlast set on the final word of
// each request. Every result word carries the empty and full flags as they
// stand after the request.
// Pipeline: a result word is registered in the pending stage and then in the
// output stage; a listing first enters the list state, which reads the elements.
// Throughput: while the pending stage can advance, the back end takes one insert
// or delete per cycle and a listing reads one element per cycle, set by the single
// read port of the store; a listing takes no new command until it ends. A
// two-entry command queue lets requests arrive while the back end is busy.
// Reset: the deque comes up empty; store contents are undefined until written.
// Stall: when m_tready is low the output word holds, the back end stops at its
// pending stage and the command queue fills, then s_tready drops.
`default_nettype none

module array_deque_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: mode[2:0], data_in[34:3], zero pad[39:35]
    input  wire logic [ard_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: status[1:0], value[33:2], is_empty[34], is_full[35], zero pad[39:36]
    output logic [ard_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast
);

    logic          cmd_valid, cmd_ready;
    ard_pkg::cmd_t cmd;
    ard_pkg::res_t res;

    ard_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_mode    (s_tdata[2:0]),
        .s_data    (s_tdata[34:3]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ard_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    assign m_tdata = {4'b0000, res.is_full, res.is_empty, res.value, res.status};
    assign m_tlast = res.last;

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_empty_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.is_empty && res.is_full))
        else $error("result flags empty and full together");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.status == ard_pkg::ST_EMPTY) |-> res.is_empty)
        else $error("empty status on a non-empty store");

    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.status != ard_pkg::ST_DONE) |-> res.last && (res.value == '0))
        else $error("failed request without last marker or with data");

endmodule

`default_nettype wire

### bench/tb_array_deque_unit.sv
// Self-checking testbench for the array deque stream block.
`timescale 1ns / 1ps

module tb_array_deque_unit;

    localparam int DEPTH = 64;
    // Codes outside the defined set; the block answers them with a plain done word
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    wire                              s_tready;
    logic [ard_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    wire                              m_tvalid;
    logic                             m_tready = 1'b0;
    wire [ard_pkg::OUT_TDATA_W-1:0]   m_tdata;
    wire                              m_tlast;

    bit gaps_on = 1'b1;
    int sent_count = 0;

    // Mirror of the deque contents plus the words it is owed by the block
    class deque_shadow;
        logic [ard_pkg::DATA_W-1:0] cells [DEPTH];
        int unsigned                head_idx;
        int unsigned                tail_idx;
        bit                         occupied;
        ard_pkg::res_t              pending_words[$];
        int                         mismatches;

        function new();
            head_idx = 0;
            tail_idx = 0;
            occupied = 1'b0;
            mismatches = 0;
        endfunction

        function void push_word(logic [1:0] st, logic [ard_pkg::DATA_W-1:0] val, bit lst);
            ard_pkg::res_t w;
            w.status   = st;
            w.value    = val;
            w.is_empty = !occupied;
            w.is_full  = occupied && (tail_idx == DEPTH - 1);
            w.last     = lst;
            pending_words.push_back(w);
        endfunction

        function void accept_request(logic [2:0] mode, logic [ard_pkg::DATA_W-1:0] data);
            int unsigned                n;
            logic [ard_pkg::DATA_W-1:0] v;
            bit                         front;
            front = (mode == ard_pkg::MODE_INS_FRONT) || (mode == ard_pkg::MODE_DEL_FRONT) ||
                    (mode == ard_pkg::MODE_LIST_FRONT);
            case (mode)
                ard_pkg::MODE_INS_FRONT, ard_pkg::MODE_INS_END: begin
                    if (!occupied) begin
                        // first element always lands in slot zero
                        head_idx = 0;
                        tail_idx = 0;
                        cells[0] = data;
                        occupied = 1'b1;
                        push_word(ard_pkg::ST_DONE, '0, 1'b1);
                    end else if (front ? (head_idx == 0) : (tail_idx == DEPTH - 1)) begin
                        push_word(ard_pkg::ST_NOROOM, '0, 1'b1);
                    end else begin
                        if (front) begin
                            head_idx--;
                            cells[head_idx] = data;
                        end else begin
                            tail_idx++;
                            cells[tail_idx] = data;
                        end
                        push_word(ard_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                ard_pkg::MODE_DEL_FRONT, ard_pkg::MODE_DEL_END: begin
                    if (!occupied) begin
                        push_word(ard_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        v = front ? cells[head_idx] : cells[tail_idx];
                        if (head_idx == tail_idx) begin
                            occupied = 1'b0;
                            head_idx = 0;
                            tail_idx = 0;
                        end else if (front) begin
                            head_idx++;
                        end else begin
                            tail_idx--;
                        end
                        push_word(ard_pkg::ST_DONE, v, 1'b1);
                    end
                end
                ard_pkg::MODE_LIST_FRONT, ard_pkg::MODE_LIST_END: begin
                    if (!occupied) begin
                        push_word(ard_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        n = tail_idx - head_idx + 1;
                        if (n > ard_pkg::MAX_RESULTS) n = ard_pkg::MAX_RESULTS;
                        for (int unsigned i = 0; i < n; i++)
                            push_word(ard_pkg::ST_DONE,
                                      cells[front ? head_idx + i : tail_idx - i],
                                      i + 1 == n);
                    end
                end
                default: push_word(ard_pkg::ST_DONE, '0, 1'b1);
            endcase
        endfunction

        function void check_word(logic [ard_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
            ard_pkg::res_t got;
            ard_pkg::res_t want;
            got.status   = tdata[1:0];
            got.value    = tdata[33:2];
            got.is_empty = tdata[34];
            got.is_full  = tdata[35];
            got.last     = tlast;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word status=%0d value=%h empty=%b full=%b last=%b",
                             $time, got.status, got.value, got.is_empty, got.is_full,
                             got.last);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: word mismatch: expected status=%0d value=%h empty=%b ",
                              "full=%b last=%b, got status=%0d value=%h empty=%b full=%b ",
                              "last=%b"}, $time, want.status, want.value, want.is_empty,
                             want.is_full, want.last, got.status, got.value, got.is_empty,
                             got.is_full, got.last);
            end
        endfunction
    endclass

    deque_shadow shadow;

    array_deque_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_request(logic [2:0] mode, logic [ard_pkg::DATA_W-1:0] data);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, data, mode};
        do @(posedge aclk); while (!s_tready);
        shadow.accept_request(mode, data);
        sent_count++;
        @(negedge aclk);
    endtask

    // Hold the input until every owed word has come back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (shadow.pending_words.size() != 0) @(negedge aclk);
    endtask

    // Walk the store out to the full mark, open room at the front, refill it
    task automatic sweep_store();
        int unsigned dropped;
        repeat (DEPTH + 2) send_request(ard_pkg::MODE_INS_END, $urandom());
        send_request(ard_pkg::MODE_LIST_FRONT, $urandom());
        send_request(ard_pkg::MODE_LIST_END, $urandom());
        dropped = $urandom_range(10, 50);
        repeat (dropped) send_request(ard_pkg::MODE_DEL_FRONT, $urandom());
        repeat (dropped + 2) send_request(ard_pkg::MODE_INS_FRONT, $urandom());
        send_request(ard_pkg::MODE_LIST_FRONT, $urandom());
        repeat ($urandom_range(5, 30)) send_request(ard_pkg::MODE_DEL_END, $urandom());
    endtask

    task automatic run_segment(int kind, int len);
        int          r;
        logic [2:0]  mode;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            case (kind)
                0: mode = (r < 85) ? ard_pkg::MODE_INS_END :
                          (r < 92) ? ard_pkg::MODE_LIST_FRONT : ard_pkg::MODE_DEL_FRONT;
                1: mode = (r < 75) ? ard_pkg::MODE_INS_FRONT :
                          (r < 90) ? ard_pkg::MODE_DEL_FRONT : ard_pkg::MODE_LIST_END;
                2: mode = (r < 45) ? ard_pkg::MODE_DEL_FRONT :
                          (r < 90) ? ard_pkg::MODE_DEL_END : ard_pkg::MODE_LIST_FRONT;
                default: mode = 3'($urandom_range(0, 7));
            endcase
            if (sent_count >= 420) gaps_on = 1'b0;
            send_request(mode, $urandom());
        end
    endtask

    // Ready side: random stall bursts until the closing stretch
    initial begin
        forever begin
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_word(m_tdata, m_tlast);
    end

    initial begin
        shadow = new();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Empty store: deletes and listings report empty, spare codes do nothing
        send_request(ard_pkg::MODE_LIST_FRONT, 32'h0);
        send_request(ard_pkg::MODE_LIST_END, 32'h0);
        send_request(ard_pkg::MODE_DEL_FRONT, 32'hFFFF_FFFF);
        send_request(ard_pkg::MODE_DEL_END, 32'h0);
        send_request(MODE_SPARE_LO, 32'h1234_5678);
        send_request(MODE_SPARE_HI, 32'hFFFF_FFFF);
        // Front insert into empty store, then front is blocked at slot zero
        send_request(ard_pkg::MODE_INS_FRONT, 32'h8000_0000);
        send_request(ard_pkg::MODE_INS_FRONT, 32'h5555_5555);
        send_request(ard_pkg::MODE_INS_END, 32'h7FFF_FFFF);
        send_request(ard_pkg::MODE_INS_END, 32'h0);
        send_request(ard_pkg::MODE_LIST_FRONT, 32'h0);
        send_request(ard_pkg::MODE_LIST_END, 32'h0);
        send_request(ard_pkg::MODE_DEL_FRONT, 32'h0);
        send_request(ard_pkg::MODE_INS_FRONT, 32'hAAAA_AAAA);
        send_request(ard_pkg::MODE_DEL_END, 32'h0);
        send_request(ard_pkg::MODE_DEL_END, 32'h0);
        // Remove the only element from each side
        send_request(ard_pkg::MODE_DEL_FRONT, 32'h0);
        send_request(ard_pkg::MODE_INS_END, 32'hFFFF_FFFF);
        send_request(ard_pkg::MODE_DEL_END, 32'h0);
        send_request(ard_pkg::MODE_INS_FRONT, 32'h0000_0001);
        send_request(ard_pkg::MODE_DEL_FRONT, 32'h0);
        send_request(ard_pkg::MODE_DEL_FRONT, 32'h0);
        wait_drained();

        sweep_store();
        wait_drained();
        while (sent_count < 480)
            run_segment($urandom_range(0, 4), $urandom_range(8, 40));
        s_tvalid = 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);

        if (shadow.mismatches == 0 && shadow.pending_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
